FILE: sv/tgr_pkg.sv
package tgr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int EV_W       = 4;
    localparam int PH_W       = 3;
    localparam int MAX_EV     = 3;
    localparam int EV_CNT_W   = 2;

    // Gesture phase codes.
    localparam logic [PH_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PH_W-1:0] PH_PRESS = 3'd1;
    localparam logic [PH_W-1:0] PH_LONG  = 3'd2;
    localparam logic [PH_W-1:0] PH_SHORT = 3'd3;
    localparam logic [PH_W-1:0] PH_MLONG = 3'd4;
    localparam logic [PH_W-1:0] PH_CLICK = 3'd5;

    // Event codes.
    localparam logic [EV_W-1:0] EV_NONE   = 4'd0;
    localparam logic [EV_W-1:0] EV_TOUCH  = 4'd1;
    localparam logic [EV_W-1:0] EV_LONG   = 4'd2;
    localparam logic [EV_W-1:0] EV_SL     = 4'd3;
    localparam logic [EV_W-1:0] EV_SR     = 4'd4;
    localparam logic [EV_W-1:0] EV_SU     = 4'd5;
    localparam logic [EV_W-1:0] EV_SD     = 4'd6;
    localparam logic [EV_W-1:0] EV_LL     = 4'd7;
    localparam logic [EV_W-1:0] EV_LR     = 4'd8;
    localparam logic [EV_W-1:0] EV_LU     = 4'd9;
    localparam logic [EV_W-1:0] EV_LD     = 4'd10;
    localparam logic [EV_W-1:0] EV_CLICK  = 4'd11;
    localparam logic [EV_W-1:0] EV_DOUBLE = 4'd12;
    localparam logic [EV_W-1:0] EV_LIFT   = 4'd13;
    localparam logic [EV_W-1:0] EV_COVER  = 4'd14;

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ZONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DC_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DC_EN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COVER_EN  = 3'd6;

    typedef struct packed {
        logic [10:0] short_thr;
        logic [10:0] long_thr;
        logic [10:0] top_zone;
        logic [7:0]  long_cnt;
        logic [15:0] dc_window;
        logic        dc_en;
        logic        cover_en;
    } t_cfg;

endpackage

FILE: sv/tgr_in_if.sv
interface tgr_in_if #(
    parameter int COORD_WIDTH = 12
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic                          pressed;
    logic signed [COORD_WIDTH-1:0] touch_x;
    logic signed [COORD_WIDTH-1:0] touch_y;
    logic [31:0]                   now_ms;

    modport source (
        output valid, operation, pressed, touch_x, touch_y, now_ms,
        input  ready
    );
    modport sink (
        input  valid, operation, pressed, touch_x, touch_y, now_ms,
        output ready
    );
endinterface

FILE: sv/tgr_out_if.sv
interface tgr_out_if #(
    parameter int COORD_WIDTH = 12
);
    logic                        valid;
    logic                        ready;
    logic [3:0]                  event_res;
    logic                        last_of_run;
    logic                        touching;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH:0]   motion_dx;
    logic signed [COORD_WIDTH:0]   motion_dy;

    modport source (
        output valid, event_res, last_of_run, touching, start_x, start_y,
               motion_dx, motion_dy,
        input  ready
    );
    modport sink (
        input  valid, event_res, last_of_run, touching, start_x, start_y,
               motion_dx, motion_dy,
        output ready
    );
endinterface

FILE: sv/touch_gesture_recognizer.sv
// Channel   Direction  Carries
// i_in      sink       operation, pressed, touch_x, touch_y, now_ms
// o_out     source     event_res, last_of_run, touching, start_x, start_y, motion_dx/dy
// i_cfg_*   write      register index and data, taken whenever i_cfg_we is high
//
// An item waits in the input register until the result buffer can load, then it updates
// the gesture state and loads its zero to three events into the result buffer.
// The result buffer sends one event per cycle while o_out.ready is high, and a new
// item may load as the last held event leaves.
// A full result buffer holds the input register, which then deasserts ready.
// Reset is synchronous and returns the phase to idle and the registers to defaults.
module touch_gesture_recognizer #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tgr_in_if.sink                         i_in,
    tgr_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = COORD_WIDTH;

    tgr_pkg::t_cfg cfg;

    logic                 r_in_vld;
    logic                 r_in_op;
    logic                 r_in_pr;
    logic signed [CW-1:0] r_in_x;
    logic signed [CW-1:0] r_in_y;
    logic [31:0]          r_in_now;

    logic                         fire;
    logic                         can_load;
    logic                         in_take;
    logic [tgr_pkg::EV_W-1:0]     ev [tgr_pkg::MAX_EV];
    logic [tgr_pkg::EV_CNT_W-1:0] ev_cnt;

    assign fire     = r_in_vld && can_load;
    assign i_in.ready = !r_in_vld || fire;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= i_in.operation;
            r_in_pr  <= i_in.pressed;
            r_in_x   <= i_in.touch_x;
            r_in_y   <= i_in.touch_y;
            r_in_now <= i_in.now_ms;
        end
    end

    tgr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tgr_core #(
        .CW (CW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_pressed  (r_in_pr),
        .i_x        (r_in_x),
        .i_y        (r_in_y),
        .i_now      (r_in_now),
        .i_cfg      (cfg),
        .o_ev       (ev),
        .o_ev_cnt   (ev_cnt),
        .o_touching (o_out.touching),
        .o_start_x  (o_out.start_x),
        .o_start_y  (o_out.start_y),
        .o_dx       (o_out.motion_dx),
        .o_dy       (o_out.motion_dy)
    );

    tgr_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_ev       (ev),
        .i_cnt      (ev_cnt),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_event    (o_out.event_res),
        .o_last     (o_out.last_of_run),
        .o_can_load (can_load)
    );

    a_no_empty_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.event_res != tgr_pkg::EV_NONE))
        else $error("result item carries no event");

    a_touch_is_touching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_res == tgr_pkg::EV_TOUCH)) |-> o_out.touching)
        else $error("touch event while the phase is idle");

    a_lift_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && ((o_out.event_res == tgr_pkg::EV_LIFT)
            || (o_out.event_res == tgr_pkg::EV_DOUBLE))) |-> !o_out.touching)
        else $error("lift or double click left the phase active");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result pending right after reset");

endmodule

FILE: sv/tgr_cfg.sv
module tgr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] i_data,
    output tgr_pkg::t_cfg                  o_cfg
);

    tgr_pkg::t_cfg r_cfg;
    tgr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                tgr_pkg::REG_SHORT_THR: n_cfg.short_thr = i_data[10:0];
                tgr_pkg::REG_LONG_THR:  n_cfg.long_thr  = i_data[10:0];
                tgr_pkg::REG_TOP_ZONE:  n_cfg.top_zone  = i_data[10:0];
                tgr_pkg::REG_LONG_CNT:  n_cfg.long_cnt  = i_data[7:0];
                tgr_pkg::REG_DC_WINDOW: n_cfg.dc_window = i_data;
                tgr_pkg::REG_DC_EN:     n_cfg.dc_en     = i_data[0];
                tgr_pkg::REG_COVER_EN:  n_cfg.cover_en  = i_data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_thr <= 11'd8;
            r_cfg.long_thr  <= 11'd80;
            r_cfg.top_zone  <= 11'd28;
            r_cfg.long_cnt  <= 8'd40;
            r_cfg.dc_window <= 16'd200;
            r_cfg.dc_en     <= 1'b1;
            r_cfg.cover_en  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/tgr_core.sv
module tgr_core #(
    parameter int CW = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_op,
    input  logic                         i_pressed,
    input  logic signed [CW-1:0]         i_x,
    input  logic signed [CW-1:0]         i_y,
    input  logic [31:0]                  i_now,
    input  tgr_pkg::t_cfg                i_cfg,
    output logic [tgr_pkg::EV_W-1:0]     o_ev [tgr_pkg::MAX_EV],
    output logic [tgr_pkg::EV_CNT_W-1:0] o_ev_cnt,
    output logic                         o_touching,
    output logic signed [CW-1:0]         o_start_x,
    output logic signed [CW-1:0]         o_start_y,
    output logic signed [CW:0]           o_dx,
    output logic signed [CW:0]           o_dy
);

    localparam int CMPW = ((CW > 11) ? CW : 11) + 2;

    logic [tgr_pkg::PH_W-1:0] r_phase, n_phase;
    logic signed [CW-1:0]     r_start_x, n_start_x, r_start_y, n_start_y;
    logic signed [CW-1:0]     r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [7:0]               r_cnt, n_cnt;
    logic [31:0]              r_stamp, n_stamp;
    logic                     r_pend, n_pend;
    logic                     r_have, n_have;
    logic signed [CW:0]       r_dx, n_dx, r_dy, n_dy;

    logic [tgr_pkg::EV_W-1:0]     ev [tgr_pkg::MAX_EV];
    logic [tgr_pkg::EV_CNT_W-1:0] cnt;
    logic signed [CW:0]           dxs, dys;
    logic [CW:0]                  mx, my;
    logic [7:0]                   cnt_inc;
    logic [31:0]                  elapsed;
    logic                         expired;
    logic                         mx_long, mx_short, my_long, my_short;
    logic                         top;
    logic                         do_swipe;
    logic                         was_short;

    // Distance from the start point to the new sample.
    assign dxs = {i_x[CW-1], i_x} - {r_start_x[CW-1], r_start_x};
    assign dys = {i_y[CW-1], i_y} - {r_start_y[CW-1], r_start_y};
    assign mx  = dxs[CW] ? (CW+1)'(-dxs) : dxs;
    assign my  = dys[CW] ? (CW+1)'(-dys) : dys;

    assign mx_long  = CMPW'(mx) >= CMPW'(i_cfg.long_thr);
    assign mx_short = CMPW'(mx) >= CMPW'(i_cfg.short_thr);
    assign my_long  = CMPW'(my) >= CMPW'(i_cfg.long_thr);
    assign my_short = CMPW'(my) >= CMPW'(i_cfg.short_thr);

    // A negative start Y is always inside the top zone.
    assign top = r_start_y[CW-1]
        || (CMPW'(unsigned'(r_start_y)) < CMPW'(i_cfg.top_zone));

    assign cnt_inc   = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
    assign elapsed   = i_now - r_stamp;
    assign expired   = elapsed >= {16'd0, i_cfg.dc_window};
    assign was_short = (r_phase == tgr_pkg::PH_SHORT);

    always_comb begin
        n_phase   = r_phase;
        n_start_x = r_start_x;
        n_start_y = r_start_y;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_cnt     = r_cnt;
        n_stamp   = r_stamp;
        n_pend    = r_pend;
        n_have    = r_have;
        n_dx      = r_dx;
        n_dy      = r_dy;
        ev        = '{default: tgr_pkg::EV_NONE};
        cnt       = '0;
        do_swipe  = 1'b0;

        if (i_op == tgr_pkg::OP_POLL) begin
            if (i_cfg.dc_en && r_pend && expired) begin
                ev[cnt] = tgr_pkg::EV_CLICK;
                cnt     = cnt + 2'd1;
                n_pend  = 1'b0;
                n_phase = tgr_pkg::PH_IDLE;
            end
        end else begin
            n_cur_x = i_x;
            n_cur_y = i_y;
            if (i_pressed) begin
                if (r_have) begin
                    n_dx = {i_x[CW-1], i_x} - {r_cur_x[CW-1], r_cur_x};
                    n_dy = {i_y[CW-1], i_y} - {r_cur_y[CW-1], r_cur_y};
                end else begin
                    n_have = 1'b1;
                    n_dx   = '0;
                    n_dy   = '0;
                end
            end else begin
                n_have = 1'b0;
            end

            if (i_cfg.cover_en && (i_x == '1)) begin
                ev[cnt] = tgr_pkg::EV_COVER;
                cnt     = cnt + 2'd1;
            end

            if (i_pressed) begin
                unique case (r_phase) inside
                    tgr_pkg::PH_IDLE, tgr_pkg::PH_CLICK: begin
                        n_start_x = i_x;
                        n_start_y = i_y;
                        n_cnt     = cnt_inc;
                        if (r_phase == tgr_pkg::PH_CLICK) begin
                            if (expired) begin
                                ev[cnt] = tgr_pkg::EV_TOUCH;
                                cnt     = cnt + 2'd1;
                                n_pend  = 1'b0;
                            end
                        end else begin
                            ev[cnt] = tgr_pkg::EV_TOUCH;
                            cnt     = cnt + 2'd1;
                        end
                        n_phase = tgr_pkg::PH_PRESS;
                    end
                    tgr_pkg::PH_PRESS: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.long_cnt) begin
                            ev[cnt] = tgr_pkg::EV_LONG;
                            cnt     = cnt + 2'd1;
                            n_phase = tgr_pkg::PH_LONG;
                        end else begin
                            do_swipe = 1'b1;
                        end
                    end
                    tgr_pkg::PH_LONG, tgr_pkg::PH_SHORT: begin
                        do_swipe = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                if (do_swipe) begin
                    if (mx >= my) begin
                        if (mx_long) begin
                            if (!was_short) begin
                                ev[cnt] = dxs[CW] ? tgr_pkg::EV_SL : tgr_pkg::EV_SR;
                                cnt     = cnt + 2'd1;
                            end
                            ev[cnt] = dxs[CW] ? tgr_pkg::EV_LL : tgr_pkg::EV_LR;
                            cnt     = cnt + 2'd1;
                            n_phase = tgr_pkg::PH_MLONG;
                        end else if (!was_short && mx_short) begin
                            ev[cnt] = dxs[CW] ? tgr_pkg::EV_SL : tgr_pkg::EV_SR;
                            cnt     = cnt + 2'd1;
                            n_phase = tgr_pkg::PH_SHORT;
                        end
                    end else begin
                        if (my_long) begin
                            if (!was_short) begin
                                if (dys[CW]) begin
                                    ev[cnt] = tgr_pkg::EV_SU;
                                    cnt     = cnt + 2'd1;
                                end else if (top) begin
                                    ev[cnt] = tgr_pkg::EV_SD;
                                    cnt     = cnt + 2'd1;
                                end
                            end
                            ev[cnt] = dys[CW] ? tgr_pkg::EV_LU : tgr_pkg::EV_LD;
                            cnt     = cnt + 2'd1;
                            n_phase = tgr_pkg::PH_MLONG;
                        end else if (!was_short && my_short) begin
                            if (dys[CW]) begin
                                ev[cnt] = tgr_pkg::EV_SU;
                                cnt     = cnt + 2'd1;
                            end else if (top) begin
                                ev[cnt] = tgr_pkg::EV_SD;
                                cnt     = cnt + 2'd1;
                            end
                            n_phase = tgr_pkg::PH_SHORT;
                        end
                    end
                end
            end else begin
                unique case (r_phase)
                    tgr_pkg::PH_PRESS: begin
                        if (i_cfg.dc_en) begin
                            if (r_pend) begin
                                ev[cnt] = tgr_pkg::EV_DOUBLE;
                                cnt     = cnt + 2'd1;
                                n_pend  = 1'b0;
                                n_phase = tgr_pkg::PH_IDLE;
                            end else begin
                                n_stamp = i_now;
                                n_pend  = 1'b1;
                                n_phase = tgr_pkg::PH_CLICK;
                            end
                        end else begin
                            ev[cnt] = tgr_pkg::EV_CLICK;
                            cnt     = cnt + 2'd1;
                            n_phase = tgr_pkg::PH_IDLE;
                        end
                    end
                    tgr_pkg::PH_CLICK: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        if (r_phase == tgr_pkg::PH_LONG) begin
                            ev[cnt] = tgr_pkg::EV_LIFT;
                            cnt     = cnt + 2'd1;
                        end
                        n_pend  = 1'b0;
                        n_phase = tgr_pkg::PH_IDLE;
                    end
                endcase
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tgr_pkg::PH_IDLE;
            r_start_x <= '0;
            r_start_y <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_cnt     <= '0;
            r_stamp   <= '0;
            r_pend    <= 1'b0;
            r_have    <= 1'b0;
            r_dx      <= '0;
            r_dy      <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_cnt     <= n_cnt;
            r_stamp   <= n_stamp;
            r_pend    <= n_pend;
            r_have    <= n_have;
            r_dx      <= n_dx;
            r_dy      <= n_dy;
        end
    end

    assign o_ev       = ev;
    assign o_ev_cnt   = cnt;
    assign o_touching = (r_phase != tgr_pkg::PH_IDLE);
    assign o_start_x  = r_start_x;
    assign o_start_y  = r_start_y;
    assign o_dx       = r_dx;
    assign o_dy       = r_dy;

endmodule

FILE: sv/tgr_outbuf.sv
module tgr_outbuf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [tgr_pkg::EV_W-1:0]     i_ev [tgr_pkg::MAX_EV],
    input  logic [tgr_pkg::EV_CNT_W-1:0] i_cnt,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [tgr_pkg::EV_W-1:0]     o_event,
    output logic                         o_last,
    output logic                         o_can_load
);

    logic [tgr_pkg::EV_W-1:0]     r_ev [tgr_pkg::MAX_EV];
    logic [tgr_pkg::EV_CNT_W-1:0] r_rd;
    logic [tgr_pkg::EV_CNT_W-1:0] r_left;
    logic                         take;

    assign o_valid    = (r_left != '0);
    assign take       = o_valid && i_ready;
    assign o_event    = r_ev[r_rd];
    assign o_last     = (r_left == 2'd1);
    // A new item may load when nothing is held or the last held result leaves this cycle.
    assign o_can_load = (r_left == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_left <= '0;
        end else if (i_load) begin
            r_rd   <= '0;
            r_left <= i_cnt;
        end else if (take) begin
            r_rd   <= r_rd + 2'd1;
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev <= i_ev;
        end
    end

endmodule

FILE: sim/touch_gesture_recognizer_test.sv
`timescale 1ns / 100ps

module touch_gesture_recognizer_test;

    localparam int COORD_W       = 12;
    localparam int CLK_HALF      = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASE_ITEMS   = 85;

    // The index past the last register; a write to it must change nothing.
    localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic                        op;
        logic                        pressed;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic [31:0]                 now;
    } t_touch_item;

    typedef struct {
        logic [tgr_pkg::EV_W-1:0]    code;
        logic                        last;
        logic                        touching;
        logic signed [COORD_W-1:0]   sx;
        logic signed [COORD_W-1:0]   sy;
        logic signed [COORD_W:0]     dx;
        logic signed [COORD_W:0]     dy;
    } t_gesture_ev;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic                            op;
        logic                            pressed;
        int                              x;
        int                              y;
        logic [31:0]                     now;
        logic [tgr_pkg::CFG_IDX_W-1:0]   reg_idx;
        int                              reg_val;
        int                              want_n;
        logic [tgr_pkg::EV_W-1:0]        want_ev;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [tgr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tgr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tgr_in_if  #(.COORD_WIDTH(COORD_W)) in_ch ();
    tgr_out_if #(.COORD_WIDTH(COORD_W)) out_ch ();

    touch_gesture_recognizer #(.COORD_WIDTH(COORD_W)) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Recognizer state as the testbench tracks it.
    tgr_pkg::t_cfg             cfg;
    logic [tgr_pkg::PH_W-1:0]  gest_phase;
    logic signed [COORD_W-1:0] start_x, start_y, cur_x, cur_y;
    logic [7:0]                press_cnt;
    logic [31:0]               click_stamp;
    logic                      click_pending, have_prev;
    logic signed [COORD_W:0]   motion_x, motion_y;

    logic [tgr_pkg::EV_W-1:0] item_events[$];
    t_gesture_ev              expected_events[$];
    t_gesture_ev              oldest;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_request   = 0;
    int          hold_left      = 0;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    logic [31:0] clock_ms       = 32'd0;

    // Time in ms for every sample; the swipe rows move across the screen extremes.
    t_dir_row directed_rows [29] = '{
        '{ROW_ITEM, tgr_pkg::OP_POLL,   1'b0,    10,    10, 32'd0,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    10,    10, 32'd1000,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,    10,    10, 32'd1010,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    10,    10, 32'd1050,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,    10,    10, 32'd1060,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_DOUBLE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,     0,     0, 32'd2000,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,     0,     0, 32'd2010,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_POLL,   1'b0,     0,     0, 32'd2210,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_CLICK},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,   100,   100, 32'd3000,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    90,   101, 32'd3010,
          tgr_pkg::REG_SHORT_THR, 0, -1, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,     0,   100, 32'd3020,
          tgr_pkg::REG_SHORT_THR, 0, -1, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,     0,   100, 32'd3030,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,  2047,  2047, 32'd4000,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1, -2048, -2048, 32'd4010,
          tgr_pkg::REG_SHORT_THR, 0, -1, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0, -2048, -2048, 32'd4020,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    50,     5, 32'd5000,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    50,   200, 32'd5010,
          tgr_pkg::REG_SHORT_THR, 0, -1, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,    50,   200, 32'd5020,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    20,    20, 32'hFFFF_FF00,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,    20,    20, 32'hFFFF_FF80,
          tgr_pkg::REG_SHORT_THR, 0, 0, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_POLL,   1'b0,    20,    20, 32'h0000_0048,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_CLICK},
        '{ROW_REG,  tgr_pkg::OP_SAMPLE, 1'b0,     0,     0, 32'd0,
          tgr_pkg::REG_LONG_CNT,  0, -1, tgr_pkg::EV_NONE},
        '{ROW_REG,  tgr_pkg::OP_SAMPLE, 1'b0,     0,     0, 32'd0,
          tgr_pkg::REG_COVER_EN,  1, -1, tgr_pkg::EV_NONE},
        '{ROW_REG,  tgr_pkg::OP_SAMPLE, 1'b0,     0,     0, 32'd0,
          tgr_pkg::REG_DC_EN,     0, -1, tgr_pkg::EV_NONE},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    -1,     0, 32'd6000,
          tgr_pkg::REG_SHORT_THR, 0, 2, tgr_pkg::EV_COVER},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,    -1,     0, 32'd6010,
          tgr_pkg::REG_SHORT_THR, 0, 2, tgr_pkg::EV_COVER},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,     5,     5, 32'd6020,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_LIFT},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b1,     5,     5, 32'd6030,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_TOUCH},
        '{ROW_ITEM, tgr_pkg::OP_SAMPLE, 1'b0,     5,     5, 32'd6040,
          tgr_pkg::REG_SHORT_THR, 0, 1, tgr_pkg::EV_CLICK}
    };

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic bit window_elapsed(input logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - click_stamp;
        return elapsed >= {16'd0, cfg.dc_window};
    endfunction

    function automatic void emit_event(input logic [tgr_pkg::EV_W-1:0] code);
        if (item_events.size() < tgr_pkg::MAX_EV) item_events.push_back(code);
    endfunction

    // Updates the tracked state with one accepted item and queues its events.
    function automatic void recognize_item(input t_touch_item it);
        int          prev_x, prev_y, mag_x, mag_y;
        bit          was_short, fired, left, up, top;
        t_gesture_ev ev;
        item_events.delete();
        if (it.op == tgr_pkg::OP_POLL) begin
            if (cfg.dc_en && click_pending && window_elapsed(it.now)) begin
                emit_event(tgr_pkg::EV_CLICK);
                click_pending = 1'b0;
                gest_phase = tgr_pkg::PH_IDLE;
            end
        end else begin
            prev_x = cur_x;
            prev_y = cur_y;
            cur_x = it.x;
            cur_y = it.y;
            if (it.pressed) begin
                if (have_prev) begin
                    motion_x = (COORD_W+1)'(int'(cur_x) - prev_x);
                    motion_y = (COORD_W+1)'(int'(cur_y) - prev_y);
                end else begin
                    have_prev = 1'b1;
                    motion_x = '0;
                    motion_y = '0;
                end
            end else begin
                have_prev = 1'b0;
            end
            if (cfg.cover_en && cur_x == -1) emit_event(tgr_pkg::EV_COVER);

            mag_x = int'(cur_x) - int'(start_x);
            mag_y = int'(cur_y) - int'(start_y);
            if (mag_x < 0) mag_x = -mag_x;
            if (mag_y < 0) mag_y = -mag_y;

            if (it.pressed) begin
                if (gest_phase == tgr_pkg::PH_IDLE || gest_phase == tgr_pkg::PH_CLICK) begin
                    start_x = cur_x;
                    start_y = cur_y;
                    if (press_cnt != 8'd255) press_cnt++;
                    // A press within the double-click window stays silent.
                    if (gest_phase == tgr_pkg::PH_CLICK) begin
                        if (window_elapsed(it.now)) begin
                            emit_event(tgr_pkg::EV_TOUCH);
                            click_pending = 1'b0;
                        end
                    end else begin
                        emit_event(tgr_pkg::EV_TOUCH);
                    end
                    gest_phase = tgr_pkg::PH_PRESS;
                end else if (gest_phase == tgr_pkg::PH_PRESS ||
                             gest_phase == tgr_pkg::PH_LONG ||
                             gest_phase == tgr_pkg::PH_SHORT) begin
                    fired = 1'b0;
                    if (gest_phase == tgr_pkg::PH_PRESS) begin
                        if (press_cnt != 8'd255) press_cnt++;
                        if (press_cnt >= cfg.long_cnt) begin
                            emit_event(tgr_pkg::EV_LONG);
                            gest_phase = tgr_pkg::PH_LONG;
                            fired = 1'b1;
                        end
                    end
                    was_short = (gest_phase == tgr_pkg::PH_SHORT);
                    if (!fired && mag_x >= mag_y) begin
                        left = cur_x < start_x;
                        if (mag_x >= int'(cfg.long_thr)) begin
                            if (!was_short) begin
                                emit_event(left ? tgr_pkg::EV_SL : tgr_pkg::EV_SR);
                            end
                            emit_event(left ? tgr_pkg::EV_LL : tgr_pkg::EV_LR);
                            gest_phase = tgr_pkg::PH_MLONG;
                        end else if (!was_short && mag_x >= int'(cfg.short_thr)) begin
                            emit_event(left ? tgr_pkg::EV_SL : tgr_pkg::EV_SR);
                            gest_phase = tgr_pkg::PH_SHORT;
                        end
                    end else if (!fired) begin
                        up = cur_y < start_y;
                        // Short-down is only reported for a touch that began in the top zone.
                        top = int'(start_y) < int'(cfg.top_zone);
                        if (mag_y >= int'(cfg.long_thr)) begin
                            if (!was_short) begin
                                if (up) emit_event(tgr_pkg::EV_SU);
                                else if (top) emit_event(tgr_pkg::EV_SD);
                            end
                            emit_event(up ? tgr_pkg::EV_LU : tgr_pkg::EV_LD);
                            gest_phase = tgr_pkg::PH_MLONG;
                        end else if (!was_short && mag_y >= int'(cfg.short_thr)) begin
                            if (up) emit_event(tgr_pkg::EV_SU);
                            else if (top) emit_event(tgr_pkg::EV_SD);
                            gest_phase = tgr_pkg::PH_SHORT;
                        end
                    end
                end
            end else begin
                if (gest_phase == tgr_pkg::PH_PRESS) begin
                    if (cfg.dc_en) begin
                        if (click_pending) begin
                            emit_event(tgr_pkg::EV_DOUBLE);
                            click_pending = 1'b0;
                            gest_phase = tgr_pkg::PH_IDLE;
                        end else begin
                            click_stamp = it.now;
                            click_pending = 1'b1;
                            gest_phase = tgr_pkg::PH_CLICK;
                        end
                    end else begin
                        emit_event(tgr_pkg::EV_CLICK);
                        gest_phase = tgr_pkg::PH_IDLE;
                    end
                end else if (gest_phase != tgr_pkg::PH_CLICK) begin
                    if (gest_phase == tgr_pkg::PH_LONG) emit_event(tgr_pkg::EV_LIFT);
                    click_pending = 1'b0;
                    gest_phase = tgr_pkg::PH_IDLE;
                end
                press_cnt = 8'd0;
            end
        end

        foreach (item_events[k]) begin
            ev.code     = item_events[k];
            ev.last     = (k == item_events.size() - 1);
            ev.touching = (gest_phase != tgr_pkg::PH_IDLE);
            ev.sx       = start_x;
            ev.sy       = start_y;
            ev.dx       = motion_x;
            ev.dy       = motion_y;
            expected_events.push_back(ev);
        end
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -1) return -1;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_item(input t_touch_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.pressed   <= it.pressed;
        in_ch.touch_x   <= it.x;
        in_ch.touch_y   <= it.y;
        in_ch.now_ms    <= it.now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        recognize_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Bits above the register's width carry random junk; the block must mask them.
    task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic [tgr_pkg::CFG_DATA_W-1:0] word;
        word = tgr_pkg::CFG_DATA_W'($urandom());
        case (idx)
            tgr_pkg::REG_SHORT_THR: begin
                word[10:0] = value[10:0];
                cfg.short_thr = word[10:0];
            end
            tgr_pkg::REG_LONG_THR: begin
                word[10:0] = value[10:0];
                cfg.long_thr = word[10:0];
            end
            tgr_pkg::REG_TOP_ZONE: begin
                word[10:0] = value[10:0];
                cfg.top_zone = word[10:0];
            end
            tgr_pkg::REG_LONG_CNT: begin
                word[7:0] = value[7:0];
                cfg.long_cnt = word[7:0];
            end
            tgr_pkg::REG_DC_WINDOW: begin
                word = value[15:0];
                cfg.dc_window = word;
            end
            tgr_pkg::REG_DC_EN: begin
                word[0] = value[0];
                cfg.dc_en = word[0];
            end
            tgr_pkg::REG_COVER_EN: begin
                word[0] = value[0];
                cfg.cover_en = word[0];
            end
            default: begin
            end
        endcase
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= word;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Items with no events may still be in flight once the queue is empty,
    // hence the settle time before anything else happens.
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_events.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_events.size()));
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly whole gestures with random content, plus some raw noise items.
    task automatic run_random_traffic(input int n_items);
        t_touch_item it;
        int          stop_at, x, y, moves, step, k, cls;
        bit          hold;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 12) begin
                it.op      = $urandom_range(1);
                it.pressed = $urandom_range(1);
                it.x       = COORD_W'($urandom());
                it.y       = COORD_W'($urandom());
                it.now     = $urandom();
                send_item(it);
            end else begin
                clock_ms += $urandom_range(1, 400);
                if ($urandom_range(99) < 4) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                x = $urandom_range(0, 2047);
                if ($urandom_range(99) < 30) y = clamp_coord($urandom_range(0, cfg.top_zone + 8));
                else y = $urandom_range(0, 2047);
                if ($urandom_range(99) < 5) x = -1;
                it.op      = tgr_pkg::OP_SAMPLE;
                it.pressed = 1'b1;
                it.x       = COORD_W'(x);
                it.y       = COORD_W'(y);
                it.now     = clock_ms;
                send_item(it);

                hold = ($urandom_range(99) < 20);
                moves = hold ? int'(cfg.long_cnt) + $urandom_range(0, 2) : $urandom_range(0, 4);
                if (moves > 40) moves = 40;
                for (k = 0; k < moves; k++) begin
                    clock_ms += $urandom_range(1, 20);
                    cls = hold ? 0 : $urandom_range(3);
                    case (cls)
                        0: step = $urandom_range(0, 2);
                        1: step = $urandom_range(0, cfg.short_thr);
                        2: step = $urandom_range(cfg.short_thr, cfg.long_thr);
                        default: step = $urandom_range(cfg.long_thr, cfg.long_thr + 60);
                    endcase
                    if ($urandom_range(1)) step = -step;
                    if ($urandom_range(1)) x = clamp_coord(x + step);
                    else y = clamp_coord(y + step);
                    if ($urandom_range(99) < 4) x = -1;
                    it.x   = COORD_W'(x);
                    it.y   = COORD_W'(y);
                    it.now = clock_ms;
                    send_item(it);
                end

                clock_ms += $urandom_range(1, 30);
                it.pressed = 1'b0;
                it.now     = clock_ms;
                send_item(it);
                if ($urandom_range(99) < 50) begin
                    clock_ms += $urandom_range(0, 2 * cfg.dc_window + 1);
                    it.op  = tgr_pkg::OP_POLL;
                    it.now = clock_ms;
                    send_item(it);
                end
            end
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event %0d arrived with nothing expected",
                                          out_ch.event_res));
            end else begin
                oldest = expected_events.pop_front();
                check_field("event_res", out_ch.event_res, oldest.code);
                check_field("last_of_run", out_ch.last_of_run, oldest.last);
                check_field("touching", out_ch.touching, oldest.touching);
                check_field("start_x", out_ch.start_x, oldest.sx);
                check_field("start_y", out_ch.start_y, oldest.sy);
                check_field("motion_dx", out_ch.motion_dx, oldest.dx);
                check_field("motion_dy", out_ch.motion_dy, oldest.dy);
            end
        end
    end

    initial begin
        t_touch_item it;
        int          p;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = tgr_pkg::OP_SAMPLE;
        in_ch.pressed   = 1'b0;
        in_ch.touch_x   = '0;
        in_ch.touch_y   = '0;
        in_ch.now_ms    = '0;
        out_ch.ready    = 1'b0;

        cfg.short_thr = 11'd8;
        cfg.long_thr  = 11'd80;
        cfg.top_zone  = 11'd28;
        cfg.long_cnt  = 8'd40;
        cfg.dc_window = 16'd200;
        cfg.dc_en     = 1'b1;
        cfg.cover_en  = 1'b0;
        gest_phase    = tgr_pkg::PH_IDLE;
        start_x       = '0;
        start_y       = '0;
        cur_x         = '0;
        cur_y         = '0;
        press_cnt     = '0;
        click_stamp   = '0;
        click_pending = 1'b0;
        have_prev     = 1'b0;
        motion_x      = '0;
        motion_y      = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                wait_drained();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                it.op      = directed_rows[r].op;
                it.pressed = directed_rows[r].pressed;
                it.x       = COORD_W'(directed_rows[r].x);
                it.y       = COORD_W'(directed_rows[r].y);
                it.now     = directed_rows[r].now;
                send_item(it);
                if (directed_rows[r].want_n >= 0 &&
                    (item_events.size() != directed_rows[r].want_n ||
                     (directed_rows[r].want_n > 0 &&
                      item_events[0] != directed_rows[r].want_ev))) begin
                    report_mismatch($sformatf("directed row %0d predicts %0d events, table %0d",
                                              r, item_events.size(), directed_rows[r].want_n));
                end
            end
        end

        for (p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin
                    write_reg(tgr_pkg::REG_SHORT_THR, 8);
                    write_reg(tgr_pkg::REG_LONG_THR, 80);
                    write_reg(tgr_pkg::REG_TOP_ZONE, 28);
                    write_reg(tgr_pkg::REG_LONG_CNT, 6);
                    write_reg(tgr_pkg::REG_DC_WINDOW, 200);
                    write_reg(tgr_pkg::REG_DC_EN, 1);
                    write_reg(tgr_pkg::REG_COVER_EN, 1);
                    write_reg(REG_UNUSED, $urandom_range(0, 65535));
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // Starve the result side so the block backs up into its input.
                    hold_request   = 120;
                end
                1: begin
                    write_reg(tgr_pkg::REG_SHORT_THR, 0);
                    write_reg(tgr_pkg::REG_LONG_THR, 2047);
                    write_reg(tgr_pkg::REG_TOP_ZONE, 2047);
                    write_reg(tgr_pkg::REG_LONG_CNT, 255);
                    write_reg(tgr_pkg::REG_DC_WINDOW, 65535);
                    write_reg(tgr_pkg::REG_DC_EN, 1);
                    write_reg(tgr_pkg::REG_COVER_EN, 0);
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_reg(tgr_pkg::REG_SHORT_THR, 2047);
                    write_reg(tgr_pkg::REG_LONG_THR, 0);
                    write_reg(tgr_pkg::REG_TOP_ZONE, 0);
                    write_reg(tgr_pkg::REG_LONG_CNT, 1);
                    write_reg(tgr_pkg::REG_DC_WINDOW, 0);
                    write_reg(tgr_pkg::REG_DC_EN, 0);
                    write_reg(tgr_pkg::REG_COVER_EN, 1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default: begin
                    write_reg(tgr_pkg::REG_SHORT_THR, $urandom_range(2, 30));
                    write_reg(tgr_pkg::REG_LONG_THR, $urandom_range(40, 300));
                    write_reg(tgr_pkg::REG_TOP_ZONE, $urandom_range(0, 400));
                    write_reg(tgr_pkg::REG_LONG_CNT, $urandom_range(2, 12));
                    write_reg(tgr_pkg::REG_DC_WINDOW, $urandom_range(10, 400));
                    write_reg(tgr_pkg::REG_DC_EN, $urandom_range(1));
                    write_reg(tgr_pkg::REG_COVER_EN, $urandom_range(1));
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            run_random_traffic(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/tgr_pkg.sv
sv/tgr_in_if.sv
sv/tgr_out_if.sv
sv/tgr_cfg.sv
sv/tgr_core.sv
sv/tgr_outbuf.sv
sv/touch_gesture_recognizer.sv
sim/touch_gesture_recognizer_test.sv
